### design/fragment_raster_op_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fragment raster operation block
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FRAGMENT_RASTER_OP_TOP_ASSERT_SVH
`define FRAGMENT_RASTER_OP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FROP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fragment_raster_op: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FROP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fragment_raster_op: next-cycle check failed");

`endif

### design/frop_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frop_pkg
// Types, constants and codes shared by the fragment raster operation block.
// ---------------------------------------------------------------------------
package frop_pkg;

  localparam int FB_COLS     = 64;
  localparam int FB_ROWS     = 64;
  localparam int FB_SIZE     = FB_COLS * FB_ROWS;
  localparam int IDX_W       = $clog2(FB_SIZE);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CFG_ADDR_W  = 5;

  localparam logic [23:0] DEPTH_FAR = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    STAT_WRITTEN    = 2'd0,
    STAT_OOB        = 2'd1,
    STAT_SCISSOR    = 2'd2,
    STAT_DEPTH_FAIL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BLEND_REPLACE = 2'd0,
    BLEND_OVER    = 2'd1,
    BLEND_ADD     = 2'd2,
    BLEND_MULT    = 2'd3
  } blend_e;

  typedef enum logic [2:0] {
    REG_DEPTH_TEST  = 3'd0,
    REG_DEPTH_WRITE = 3'd1,
    REG_BLEND       = 3'd2,
    REG_SCIS_ON     = 3'd3,
    REG_SCIS_LEFT   = 3'd4,
    REG_SCIS_TOP    = 3'd5,
    REG_SCIS_COLS   = 3'd6,
    REG_SCIS_ROWS   = 3'd7
  } reg_idx_e;

  // Color channels are packed red, green, blue, alpha from index 0 up.
  localparam int CH_ALPHA = 3;
  typedef logic [3:0][7:0] rgba_t;

  typedef struct packed {
    logic        on;
    logic [10:0] left_col;
    logic [10:0] top_row;
    logic [11:0] cols;
    logic [11:0] rows;
  } scis_cfg_t;

  typedef struct packed {
    logic   depth_test_on;
    logic   depth_write_on;
    blend_e blend;
  } rop_cfg_t;

  // One classified fragment: cls is STAT_WRITTEN while its depth test is open.
  typedef struct packed {
    status_e          cls;
    logic [IDX_W-1:0] idx;
    logic [23:0]      depth;
    rgba_t            color;
  } frag_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### design/frop_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frop_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
module frop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/frop_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frop_front
// Accepts fragments, tests bounds and scissor, forms the pixel index.
// ---------------------------------------------------------------------------
module frop_front (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [11:0]        pixel_x_i,
  input  logic signed [11:0]        pixel_y_i,
  input  logic [23:0]               frag_depth_i,
  input  logic [7:0]                src_red_i,
  input  logic [7:0]                src_green_i,
  input  logic [7:0]                src_blue_i,
  input  logic [7:0]                src_alpha_i,
  input  frop_pkg::scis_cfg_t       scis_cfg_i,
  input  logic                      clearing_i,
  input  frop_pkg::q_stat_t         q_stat_i,
  output logic                      push_o,
  output frop_pkg::frag_t           frag_o
);
  import frop_pkg::*;

  logic        oob;
  logic        outside;
  logic [12:0] ux;
  logic [12:0] uy;
  logic [12:0] x_end;
  logic [12:0] y_end;
  logic [23:0] idx_full;

  always_comb begin
    oob = pixel_x_i[11] || pixel_y_i[11] ||
          ({1'b0, pixel_x_i[10:0]} >= 12'(FB_COLS)) ||
          ({1'b0, pixel_y_i[10:0]} >= 12'(FB_ROWS));

    // Scissor sums are one bit wider so they never wrap.
    ux      = {2'b00, pixel_x_i[10:0]};
    uy      = {2'b00, pixel_y_i[10:0]};
    x_end   = {2'b00, scis_cfg_i.left_col} + {1'b0, scis_cfg_i.cols};
    y_end   = {2'b00, scis_cfg_i.top_row} + {1'b0, scis_cfg_i.rows};
    outside = scis_cfg_i.on &&
              ((ux < {2'b00, scis_cfg_i.left_col}) || (ux >= x_end) ||
               (uy < {2'b00, scis_cfg_i.top_row}) || (uy >= y_end));

    idx_full = 24'(pixel_y_i[10:0]) * 24'(FB_COLS) + 24'(pixel_x_i[10:0]);

    frag_o.idx   = idx_full[IDX_W-1:0];
    frag_o.depth = frag_depth_i;
    frag_o.color = {src_alpha_i, src_blue_i, src_green_i, src_red_i};
    if (oob) begin
      frag_o.cls = STAT_OOB;
    end else if (outside) begin
      frag_o.cls = STAT_SCISSOR;
    end else begin
      frag_o.cls = STAT_WRITTEN;
    end
  end

  assign in_stall_o = q_stat_i.full || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

endmodule

### design/frop_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frop_queue
// Short fragment queue between the front and back sections.
// ---------------------------------------------------------------------------
module frop_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  frop_pkg::frag_t   frag_i,
  input  logic              pop_i,
  output frop_pkg::frag_t   head_o,
  output frop_pkg::q_stat_t stat_o
);
  import frop_pkg::*;

  frag_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= frag_i;
    end
  end

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

### design/frop_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frop_back
// Clears the stores, runs the depth test and blend, writes back, and
// holds the result register.
// ---------------------------------------------------------------------------
module frop_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frop_pkg::rop_cfg_t rop_cfg_i,
  input  frop_pkg::frag_t    head_i,
  input  frop_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frag_status_o,
  output logic [7:0]         pix_red_o,
  output logic [7:0]         pix_green_o,
  output logic [7:0]         pix_blue_o,
  output logic [7:0]         pix_alpha_o,
  output logic [23:0]        pix_depth_o
);
  import frop_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_MIX,
    ST_DONE
  } state_e;

  state_e           state_q;
  state_e           state_d;
  logic [IDX_W-1:0] clr_cnt_q;

  frag_t             item_q;
  rgba_t             cur_q;
  logic [23:0]       cur_depth_q;
  status_e           status_q;
  status_e           status_d;
  logic [3:0][15:0]  prod_q;
  logic [3:0][15:0]  prod_d;
  rgba_t             res_color_q;
  logic [23:0]       res_depth_q;
  rgba_t             blend_color;

  logic             color_we;
  logic             depth_we;
  logic [IDX_W-1:0] waddr;
  rgba_t            color_wdata;
  logic [23:0]      depth_wdata;
  rgba_t            color_rdata;
  logic [23:0]      depth_rdata;
  logic             out_free;

  logic             out_valid_q;
  logic [1:0]       out_status_q;
  rgba_t            out_color_q;
  logic [23:0]      out_depth_q;

  frop_ram #(.WIDTH(32), .DEPTH(FB_SIZE)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (waddr),
    .wdata_i (color_wdata),
    .raddr_i (head_i.idx),
    .rdata_o (color_rdata)
  );

  frop_ram #(.WIDTH(24), .DEPTH(FB_SIZE)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (depth_we),
    .waddr_i (waddr),
    .wdata_i (depth_wdata),
    .raddr_i (head_i.idx),
    .rdata_o (depth_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_stat_i.empty;

  // Test against the stored pixel and form the blend products.
  always_comb begin
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] a;
    a = item_q.color[CH_ALPHA];
    if (item_q.cls == STAT_SCISSOR) begin
      status_d = STAT_SCISSOR;
    end else if (rop_cfg_i.depth_test_on && (item_q.depth >= depth_rdata)) begin
      status_d = STAT_DEPTH_FAIL;
    end else begin
      status_d = STAT_WRITTEN;
    end
    for (int c = 0; c < 4; c++) begin
      if (rop_cfg_i.blend == BLEND_MULT) begin
        m1 = color_rdata[c];
        m2 = 8'd0;
      end else begin
        m1 = (c == CH_ALPHA) ? 8'hFF : a;
        m2 = 8'hFF - a;
      end
      prod_d[c] = 16'(item_q.color[c]) * 16'(m1) + 16'(color_rdata[c]) * 16'(m2);
    end
  end

  // Final channel values; division by 255 is a reciprocal multiply.
  always_comb begin
    logic [31:0] recip;
    logic [8:0]  sum;
    for (int c = 0; c < 4; c++) begin
      recip = 32'(prod_q[c]) * 32'h0000_8081;
      sum   = {1'b0, item_q.color[c]} + {1'b0, cur_q[c]};
      case (rop_cfg_i.blend)
        BLEND_REPLACE: blend_color[c] = item_q.color[c];
        BLEND_ADD:     blend_color[c] = sum[8] ? 8'hFF : sum[7:0];
        default:       blend_color[c] = recip[30:23];
      endcase
    end
  end

  always_comb begin
    color_we    = 1'b0;
    depth_we    = 1'b0;
    waddr       = item_q.idx;
    color_wdata = blend_color;
    depth_wdata = item_q.depth;
    if (state_q == ST_CLEAR) begin
      color_we    = 1'b1;
      depth_we    = 1'b1;
      waddr       = clr_cnt_q;
      color_wdata = '0;
      depth_wdata = DEPTH_FAR;
    end else if (state_q == ST_MIX && status_q == STAT_WRITTEN) begin
      color_we = 1'b1;
      depth_we = rop_cfg_i.depth_write_on;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == IDX_W'(FB_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = (head_i.cls == STAT_OOB) ? ST_DONE : ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_MIX;
      ST_MIX:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_color_q  <= '0;
      out_depth_q  <= DEPTH_FAR;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        out_color_q  <= res_color_q;
        out_depth_q  <= res_depth_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        item_q      <= head_i;
        status_q    <= STAT_OOB;
        res_color_q <= '0;
        res_depth_q <= DEPTH_FAR;
      end
      ST_LOOK: begin
        status_q    <= status_d;
        cur_q       <= color_rdata;
        cur_depth_q <= depth_rdata;
        prod_q      <= prod_d;
      end
      ST_MIX: begin
        if (status_q == STAT_WRITTEN) begin
          res_color_q <= blend_color;
          res_depth_q <= rop_cfg_i.depth_write_on ? item_q.depth : cur_depth_q;
        end else begin
          res_color_q <= cur_q;
          res_depth_q <= cur_depth_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign clearing_o    = (state_q == ST_CLEAR);
  assign out_valid_o   = out_valid_q;
  assign frag_status_o = out_status_q;
  assign pix_red_o     = out_color_q[0];
  assign pix_green_o   = out_color_q[1];
  assign pix_blue_o    = out_color_q[2];
  assign pix_alpha_o   = out_color_q[CH_ALPHA];
  assign pix_depth_o   = out_depth_q;

endmodule

### design/fragment_raster_op_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fragment_raster_op_top
// Raster back end: bounds, scissor and depth tests, blend and write-back
// of single fragments into on-chip color and depth stores.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Contents
// in        input      in_valid_i / in_stall_o   pixel x, y, depth, RGBA
// out       output     out_valid_o / out_stall_i status, stored RGBA, depth
// config    input      APB psel/penable/pwrite   eight control registers
//
// An in-bounds fragment passes through the back section in order (RAM read,
// depth test with blend products, divide and write-back, result load); an
// out-of-bounds one goes from the RAM read straight to the result load. The
// read-modify-write sequencer sets this. After reset a clearing pass writes
// all 4096 entries of both stores, one per cycle, holding in_stall_o high
// throughout. A two-entry queue accepts fragments until it is full while the
// back section or result register stalls.
`include "fragment_raster_op_top_assert.svh"

module fragment_raster_op_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Fragment input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [11:0]                  pixel_x_i,
  input  logic signed [11:0]                  pixel_y_i,
  input  logic [23:0]                         frag_depth_i,
  input  logic [7:0]                          src_red_i,
  input  logic [7:0]                          src_green_i,
  input  logic [7:0]                          src_blue_i,
  input  logic [7:0]                          src_alpha_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          frag_status_o,
  output logic [7:0]                          pix_red_o,
  output logic [7:0]                          pix_green_o,
  output logic [7:0]                          pix_blue_o,
  output logic [7:0]                          pix_alpha_o,
  output logic [23:0]                         pix_depth_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [frop_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import frop_pkg::*;

  // Configuration registers.
  logic        depth_test_on_q;
  logic        depth_write_on_q;
  logic [1:0]  blend_select_q;
  logic        scissor_on_q;
  logic [10:0] scissor_left_q;
  logic [10:0] scissor_top_q;
  logic [11:0] scissor_cols_q;
  logic [11:0] scissor_rows_q;

  logic      cfg_write;
  reg_idx_e  cfg_idx;
  scis_cfg_t scis_cfg;
  rop_cfg_t  rop_cfg;

  frag_t   front_frag;
  frag_t   q_head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    clearing;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);

  // A register transaction completes in the access phase. Software must write
  // only when idle, unchecked by the block; the datapath reads these directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_test_on_q  <= 1'b1;
      depth_write_on_q <= 1'b1;
      blend_select_q   <= BLEND_REPLACE;
      scissor_on_q     <= 1'b0;
      scissor_left_q   <= '0;
      scissor_top_q    <= '0;
      scissor_cols_q   <= 12'd64;
      scissor_rows_q   <= 12'd64;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_DEPTH_TEST:  depth_test_on_q  <= pwdata[0];
        REG_DEPTH_WRITE: depth_write_on_q <= pwdata[0];
        REG_BLEND:       blend_select_q   <= pwdata[1:0];
        REG_SCIS_ON:     scissor_on_q     <= pwdata[0];
        REG_SCIS_LEFT:   scissor_left_q   <= pwdata[10:0];
        REG_SCIS_TOP:    scissor_top_q    <= pwdata[10:0];
        REG_SCIS_COLS:   scissor_cols_q   <= pwdata[11:0];
        REG_SCIS_ROWS:   scissor_rows_q   <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEPTH_TEST:  prdata = 32'(depth_test_on_q);
      REG_DEPTH_WRITE: prdata = 32'(depth_write_on_q);
      REG_BLEND:       prdata = 32'(blend_select_q);
      REG_SCIS_ON:     prdata = 32'(scissor_on_q);
      REG_SCIS_LEFT:   prdata = 32'(scissor_left_q);
      REG_SCIS_TOP:    prdata = 32'(scissor_top_q);
      REG_SCIS_COLS:   prdata = 32'(scissor_cols_q);
      REG_SCIS_ROWS:   prdata = 32'(scissor_rows_q);
      default:         prdata = '0;
    endcase
  end

  assign scis_cfg.on       = scissor_on_q;
  assign scis_cfg.left_col = scissor_left_q;
  assign scis_cfg.top_row  = scissor_top_q;
  assign scis_cfg.cols     = scissor_cols_q;
  assign scis_cfg.rows     = scissor_rows_q;

  assign rop_cfg.depth_test_on  = depth_test_on_q;
  assign rop_cfg.depth_write_on = depth_write_on_q;
  assign rop_cfg.blend          = blend_e'(blend_select_q);

  // Front section: classifies each fragment as it is accepted.
  frop_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .frag_depth_i (frag_depth_i),
    .src_red_i    (src_red_i),
    .src_green_i  (src_green_i),
    .src_blue_i   (src_blue_i),
    .src_alpha_i  (src_alpha_i),
    .scis_cfg_i   (scis_cfg),
    .clearing_i   (clearing),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .frag_o       (front_frag)
  );

  frop_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .frag_i (front_frag),
    .pop_i  (pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // Back section: read-modify-write sequencer over the pixel stores.
  frop_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rop_cfg_i     (rop_cfg),
    .head_i        (q_head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frag_status_o (frag_status_o),
    .pix_red_o     (pix_red_o),
    .pix_green_o   (pix_green_o),
    .pix_blue_o    (pix_blue_o),
    .pix_alpha_o   (pix_alpha_o),
    .pix_depth_o   (pix_depth_o)
  );

  // No fragment enters while the stores are being cleared.
  `FROP_ASSERT_SAME(a_clear_stalls, clearing, in_stall_o)
  // The queue holds nothing during the clearing pass.
  `FROP_ASSERT_SAME(a_clear_queue_empty, clearing, q_stat.empty)
  // An out-of-bounds result reports a blank pixel at far depth.
  `FROP_ASSERT_SAME(a_oob_blank, out_valid_o && (frag_status_o == STAT_OOB),
    (pix_red_o == 8'd0) && (pix_green_o == 8'd0) && (pix_blue_o == 8'd0) &&
    (pix_alpha_o == 8'd0) && (pix_depth_o == DEPTH_FAR))
  // A pop happens only when the queue has an entry.
  `FROP_ASSERT_SAME(a_pop_nonempty, pop, !q_stat.empty)

endmodule
